// File: rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tick task scheduler table.
package tts_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int HANDLE_W      = 8;
    localparam int TIME_W        = 16;
    localparam int PEND_W        = 8;
    localparam int SLOT_IN_W     = 4;
    localparam int SLOT_OUT_W    = 5;
    localparam int HOLD_TICKS_RST = 60000;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_DISP = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_RUN = 2'd0,
        KIND_ADD = 2'd1,
        KIND_DEL = 2'd2,
        KIND_ERR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_DEL  = 2'd2
    } err_t;

    // One task slot as stored in the slot memory.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [PEND_W-1:0]   pending;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [HANDLE_W-1:0]   handle;
        err_t                  code;
    } res_t;

    // Engine to result queue: push a new result, or release the held one as last.
    typedef struct packed {
        logic emit;
        logic flush;
    } rq_ctl_t;

    typedef struct packed {
        logic hold_valid;
        logic can_push;
    } rq_stat_t;

    typedef struct packed {
        logic              report_enable;
        logic [TIME_W-1:0] hold_ticks;
    } cfg_t;

endpackage

// File: rtl/core/tts_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/tts_result_q.sv
`timescale 1ns / 1ps
// Result holding stage and output register; the held result learns its last flag late.
module tts_result_q
    import tts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rq_ctl_t  ctl,
    input  res_t     res,
    output rq_stat_t stat,
    output logic     out_valid,
    input  logic     out_stall,
    output res_t     out_res,
    output logic     out_last
);

    logic hold_valid_reg, hold_valid_next;
    res_t hold_reg;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    logic out_last_reg;
    logic push;

    assign stat.hold_valid = hold_valid_reg;
    assign stat.can_push   = !out_valid_reg || !out_stall;

    // A new result pushes the held one out as not last; flush pushes it as last.
    assign push = (ctl.emit && hold_valid_reg) || ctl.flush;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        hold_valid_next = hold_valid_reg;
        if (ctl.emit)
        begin
            hold_valid_next = 1'b1;
        end
        else if (ctl.flush)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            hold_reg <= res;
        end
        if (push)
        begin
            out_res_reg  <= hold_reg;
            out_last_reg <= ctl.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/core/tts_slot_engine.sv
`timescale 1ns / 1ps
// Request sequencer: walks the slot memory with read-modify-write and keeps the error state.
module tts_slot_engine
    import tts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [HANDLE_W-1:0]   task_handle,
    input  logic [TIME_W-1:0]     first_delay,
    input  logic [TIME_W-1:0]     period,
    input  logic [SLOT_IN_W-1:0]  slot,
    input  cfg_t                  cfg,
    input  rq_stat_t              rq_stat,
    output rq_ctl_t               rq_ctl,
    output res_t                  res
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_REPORT,
        ST_FLUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     rd_end_reg, rd_end_next;
    logic                 p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0]     p1_idx_reg, p1_idx_next;
    logic                 p1_live_reg, p1_live_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    err_t                 cur_err_reg, cur_err_next;
    err_t                 rep_err_reg, rep_err_next;
    logic [TIME_W-1:0]    hold_cnt_reg, hold_cnt_next;

    req_t                 op_reg;
    logic [HANDLE_W-1:0]  hdl_reg;
    logic [TIME_W-1:0]    dly_reg;
    logic [TIME_W-1:0]    per_reg;
    logic [SLOT_IN_W-1:0] slot_reg;
    logic                 item_load;

    logic                 ram_we;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               ent;
    entry_t               upd;
    logic                 emit_ok;
    logic                 go;
    logic                 stop;

    tts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p1_idx_reg),
        .wdata (upd),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // A slot never written since reset reads as free.
    assign ent      = p1_live_reg ? entry_t'(ram_rdata) : '0;
    assign emit_ok  = !rq_stat.hold_valid || rq_stat.can_push;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        rd_end_next   = rd_end_reg;
        p1_valid_next = p1_valid_reg;
        p1_idx_next   = p1_idx_reg;
        p1_live_next  = p1_live_reg;
        valid_next    = valid_reg;
        cur_err_next  = cur_err_reg;
        rep_err_next  = rep_err_reg;
        hold_cnt_next = hold_cnt_reg;
        item_load     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        upd           = ent;
        go            = 1'b1;
        stop          = 1'b0;
        rq_ctl        = '0;
        res.kind      = KIND_RUN;
        res.slot      = SLOT_OUT_W'(p1_idx_reg);
        res.handle    = '0;
        res.code      = ERR_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_load     = 1'b1;
                    state_next    = ST_WALK;
                    p1_valid_next = 1'b0;
                    rd_idx_next   = '0;
                    rd_end_next   = CNT_W'(NUM_SLOTS);
                    if (req_t'(req_type) == REQ_DEL)
                    begin
                        if (int'(slot) < NUM_SLOTS)
                        begin
                            rd_idx_next = CNT_W'(slot);
                            rd_end_next = CNT_W'(slot) + CNT_W'(1);
                        end
                        else
                        begin
                            rd_end_next = '0;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (p1_valid_reg)
                begin
                    case (op_reg)
                        REQ_TICK:
                        begin
                            if (ent.handle != '0)
                            begin
                                ram_we = 1'b1;
                                if (ent.delay == '0)
                                begin
                                    if (ent.pending != '1)
                                    begin
                                        upd.pending = ent.pending + PEND_W'(1);
                                    end
                                    if (ent.period != '0)
                                    begin
                                        upd.delay = ent.period;
                                    end
                                end
                                else
                                begin
                                    upd.delay = ent.delay - TIME_W'(1);
                                end
                            end
                        end

                        REQ_ADD:
                        begin
                            if (ent.handle == '0)
                            begin
                                ram_we      = 1'b1;
                                upd.handle  = hdl_reg;
                                upd.delay   = dly_reg;
                                upd.period  = per_reg;
                                upd.pending = '0;
                                rq_ctl.emit = 1'b1;
                                res.kind    = KIND_ADD;
                                stop        = 1'b1;
                            end
                        end

                        REQ_DEL:
                        begin
                            ram_we      = 1'b1;
                            upd         = '0;
                            rq_ctl.emit = 1'b1;
                            res.kind    = KIND_DEL;
                            res.slot    = SLOT_OUT_W'(slot_reg);
                            if (ent.handle == '0)
                            begin
                                cur_err_next = ERR_DEL;
                                res.code     = ERR_DEL;
                            end
                            stop = 1'b1;
                        end

                        REQ_DISP:
                        begin
                            if (ent.pending != '0)
                            begin
                                if (emit_ok)
                                begin
                                    ram_we      = 1'b1;
                                    rq_ctl.emit = 1'b1;
                                    res.handle  = ent.handle;
                                    upd.pending = ent.pending - PEND_W'(1);
                                    // one-shot task: free the slot after its run
                                    if (ent.period == '0)
                                    begin
                                        upd = '0;
                                        if (ent.handle == '0)
                                        begin
                                            cur_err_next = ERR_DEL;
                                        end
                                    end
                                end
                                else
                                begin
                                    go = 1'b0;
                                end
                            end
                        end

                        default:
                        begin
                            go = 1'b1;
                        end
                    endcase
                end

                if (stop)
                begin
                    p1_valid_next = 1'b0;
                    state_next    = ST_FLUSH;
                end
                else if (go)
                begin
                    if (rd_idx_reg < rd_end_reg)
                    begin
                        ram_re        = 1'b1;
                        p1_valid_next = 1'b1;
                        p1_idx_next   = rd_idx_reg[IDX_W-1:0];
                        p1_live_next  = valid_reg[rd_idx_reg[IDX_W-1:0]];
                        rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        p1_valid_next = 1'b0;
                        if (!p1_valid_reg)
                        begin
                            // walk finished with nothing in flight
                            state_next = ST_FLUSH;
                            case (op_reg)
                                REQ_ADD:
                                begin
                                    cur_err_next = ERR_FULL;
                                    rq_ctl.emit  = 1'b1;
                                    res.kind     = KIND_ADD;
                                    res.slot     = SLOT_OUT_W'(NUM_SLOTS);
                                    res.code     = ERR_FULL;
                                end
                                REQ_DEL:
                                begin
                                    // slot index beyond the table
                                    cur_err_next = ERR_DEL;
                                    rq_ctl.emit  = 1'b1;
                                    res.kind     = KIND_DEL;
                                    res.slot     = SLOT_OUT_W'(slot_reg);
                                    res.code     = ERR_DEL;
                                end
                                REQ_DISP:
                                begin
                                    state_next = ST_REPORT;
                                end
                                default:
                                begin
                                    state_next = ST_FLUSH;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_REPORT:
            begin
                state_next = ST_FLUSH;
                if (cfg.report_enable)
                begin
                    if (cur_err_reg != rep_err_reg)
                    begin
                        if (emit_ok)
                        begin
                            rq_ctl.emit   = 1'b1;
                            res.kind      = KIND_ERR;
                            res.slot      = '0;
                            res.code      = cur_err_reg;
                            rep_err_next  = cur_err_reg;
                            hold_cnt_next = (cur_err_reg != ERR_NONE) ? cfg.hold_ticks : '0;
                        end
                        else
                        begin
                            state_next = ST_REPORT;
                        end
                    end
                    else if (hold_cnt_reg != '0)
                    begin
                        hold_cnt_next = hold_cnt_reg - TIME_W'(1);
                        if (hold_cnt_reg == TIME_W'(1))
                        begin
                            cur_err_next = ERR_NONE;
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                if (rq_stat.hold_valid)
                begin
                    if (rq_stat.can_push)
                    begin
                        rq_ctl.flush = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[p1_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            rd_end_reg   <= '0;
            p1_valid_reg <= 1'b0;
            p1_idx_reg   <= '0;
            p1_live_reg  <= 1'b0;
            valid_reg    <= '0;
            cur_err_reg  <= ERR_NONE;
            rep_err_reg  <= ERR_NONE;
            hold_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            rd_end_reg   <= rd_end_next;
            p1_valid_reg <= p1_valid_next;
            p1_idx_reg   <= p1_idx_next;
            p1_live_reg  <= p1_live_next;
            valid_reg    <= valid_next;
            cur_err_reg  <= cur_err_next;
            rep_err_reg  <= rep_err_next;
            hold_cnt_reg <= hold_cnt_next;
        end
    end

    // hold the request fields for the duration of the walk
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            op_reg   <= req_t'(req_type);
            hdl_reg  <= task_handle;
            dly_reg  <= first_delay;
            per_reg  <= period;
            slot_reg <= slot;
        end
    end

endmodule

// File: rtl/core/tick_task_scheduler_table_unit.sv
`timescale 1ns / 1ps
// Top level of the tick task scheduler table: config registers, engine and result queue.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    req_type task_handle first_delay period slot
//   out      from block out_valid / out_stall  kind slot_out handle_out code last
//   config   to block   APB psel/penable       paddr pwdata prdata (pready tied high)
//
// One request at a time. Tick walks the slot memory, one slot read per cycle through its
// single read port; dispatch walks it too, then steps on to the error report.
// Add stops at the first free slot or, when the table is full, after the last one; delete
// reads only the addressed slot, and no slot at all for a slot index beyond the table.
// Reset clears per-slot valid bits at once; no clearing pass is needed.
// A stalled output holds the walk at the next result; in_stall stays high meanwhile.
module tick_task_scheduler_table_unit
    import tts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [HANDLE_W-1:0]   task_handle,
    input  logic [TIME_W-1:0]     first_delay,
    input  logic [TIME_W-1:0]     period,
    input  logic [SLOT_IN_W-1:0]  slot,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [SLOT_OUT_W-1:0] slot_out,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic [1:0]            code,
    output logic                  last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t     cfg_reg;
    logic     cfg_wr;
    rq_ctl_t  rq_ctl;
    rq_stat_t rq_stat;
    res_t     res;
    res_t     out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // registers sit on word boundaries; bit 2 picks the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_enable <= 1'b1;
            cfg_reg.hold_ticks    <= TIME_W'(HOLD_TICKS_RST);
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                cfg_reg.hold_ticks <= pwdata[TIME_W-1:0];
            end
            else
            begin
                cfg_reg.report_enable <= pwdata[0];
            end
        end
    end

    assign prdata = paddr[2] ? {{(32-TIME_W){1'b0}}, cfg_reg.hold_ticks}
                             : {31'b0, cfg_reg.report_enable};

    tts_slot_engine #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .task_handle (task_handle),
        .first_delay (first_delay),
        .period      (period),
        .slot        (slot),
        .cfg         (cfg_reg),
        .rq_stat     (rq_stat),
        .rq_ctl      (rq_ctl),
        .res         (res)
    );

    tts_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rq_ctl),
        .res       (res),
        .stat      (rq_stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .out_last  (last)
    );

    assign kind       = out_res.kind;
    assign slot_out   = out_res.slot;
    assign handle_out = out_res.handle;
    assign code       = out_res.code;

    // a new request starts only after the previous one released its last result
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !rq_stat.hold_valid)
        else $error("request taken while a result is still held");

    a_emit_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rq_ctl.emit && rq_stat.hold_valid |-> rq_stat.can_push)
        else $error("result pushed into a full output register");

    a_emit_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rq_ctl.emit && rq_ctl.flush))
        else $error("emit and flush in the same cycle");

    a_flush_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        rq_ctl.flush |=> out_valid && last)
        else $error("flush did not present a last result");

endmodule
